// ===== sv/ogru_pkg.sv =====
// Package for the occupancy grid ray update block.
// Holds the update request type, request kinds and register indexes.
// No dependencies.
package ogru_pkg;

  localparam int unsigned CELL_W  = 16;
  localparam int unsigned WEIGHT_W = 15;
  localparam int unsigned COORD_W = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ERR_W   = 10;

  localparam logic REG_OCCUPIED_WEIGHT = 1'b0;
  localparam logic REG_FREE_WEIGHT     = 1'b1;

  localparam logic [2:0] KIND_FREE   = 3'd0;
  localparam logic [2:0] KIND_OCC    = 3'd1;
  localparam logic [2:0] KIND_CENTER = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_ZERO   = 3'd4;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
  } upd_req_t;

endpackage

// ===== sv/occupancy_grid_ray_update.sv =====
// Occupancy grid ray update, top level: configuration registers and the grid datapath.
// Uses ogru_pkg, ogru_grid_mem, ogru_cell_update and ogru_ray_seq.
//
// The block keeps a GRID_SIDE x GRID_SIDE grid of Q8.8 log-odds cells in one memory.
// After reset a clearing pass writes zero to every cell, during which no request is
// taken. The memory does one read-modify-write per cycle, which sets the walk of a ray
// request at one cell per cycle. One request is worked on at a time, and the next is
// taken while a result waits in the output register.
module occupancy_grid_ray_update #(
  parameter int unsigned GRID_SIDE = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [ogru_pkg::COORD_W-1:0]  in_start_x,
  input  logic [ogru_pkg::COORD_W-1:0]  in_start_y,
  input  logic [ogru_pkg::COORD_W-1:0]  in_end_x,
  input  logic [ogru_pkg::COORD_W-1:0]  in_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ogru_pkg::cell_t               out_cell_value,
  output logic                          out_cell_occupied,
  output logic [ogru_pkg::COUNT_W-1:0]  out_cells_touched,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ogru_pkg::WEIGHT_W-1:0] cfg_data
);
  import ogru_pkg::*;

  localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [WEIGHT_W-1:0] occupied_weight_r;
  logic [WEIGHT_W-1:0] free_weight_r;

  upd_req_t       req;
  logic [AW-1:0]  req_addr;
  logic           clr_busy;
  cell_t          cap;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  cell_t          rd_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  cell_t          wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_weight_r <= WEIGHT_W'(166);
      free_weight_r     <= WEIGHT_W'(166);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCCUPIED_WEIGHT: occupied_weight_r <= cfg_data;
        REG_FREE_WEIGHT:     free_weight_r     <= cfg_data;
        default:             occupied_weight_r <= occupied_weight_r;
      endcase
    end
  end

  ogru_ray_seq #(
    .GRID_SIDE (GRID_SIDE),
    .AW        (AW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_value    (out_cell_value),
    .out_cell_occupied (out_cell_occupied),
    .out_cells_touched (out_cells_touched),
    .clr_busy_i        (clr_busy),
    .cap_i             (cap),
    .req_o             (req),
    .addr_o            (req_addr)
  );

  ogru_cell_update #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_update (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_i           (req),
    .addr_i          (req_addr),
    .occupied_weight (occupied_weight_r),
    .free_weight     (free_weight_r),
    .clr_busy_o      (clr_busy),
    .cap_o           (cap),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  ogru_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== sv/ogru_grid_mem.sv =====
// Log-odds grid storage: one write port and one read port, read data registered.
// Uses ogru_pkg for the cell type.
module ogru_grid_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ogru_pkg::cell_t  rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ogru_pkg::cell_t  wr_data
);
  import ogru_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ogru_cell_update.sv =====
// Read-modify-write stage of the grid: saturating add, forwarding and the clearing pass.
// Uses ogru_pkg; drives the ports of ogru_grid_mem.
module ogru_cell_update #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ogru_pkg::upd_req_t                req_i,
  input  logic [AW-1:0]                     addr_i,
  input  logic [ogru_pkg::WEIGHT_W-1:0]     occupied_weight,
  input  logic [ogru_pkg::WEIGHT_W-1:0]     free_weight,
  output logic                              clr_busy_o,
  output ogru_pkg::cell_t                   cap_o,
  output logic                              rd_en_o,
  output logic [AW-1:0]                     rd_addr_o,
  input  ogru_pkg::cell_t                   rd_data_i,
  output logic                              wr_en_o,
  output logic [AW-1:0]                     wr_addr_o,
  output ogru_pkg::cell_t                   wr_data_o
);
  import ogru_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  upd_req_t       p_req_r;
  logic [AW-1:0]  p_addr_r;
  logic           fwd_r;
  cell_t          fwd_data_r;
  logic           clr_busy_r;
  logic [AW-1:0]  clr_addr_r;
  cell_t          cap_r;

  cell_t              operand;
  logic signed [17:0] delta;
  logic signed [17:0] sum;
  cell_t              sat_val;
  logic               upd_wr;

  always_comb begin
    operand = fwd_r ? fwd_data_r : rd_data_i;
    if (p_req_r.kind == KIND_FREE) begin
      delta = -$signed({3'b000, free_weight});
    end else begin
      delta = $signed({3'b000, occupied_weight});
    end
    sum = $signed({{2{operand[15]}}, operand}) + delta;
    if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
      sat_val = sum[15:0];
    end else if (sum[17]) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = 16'sh7FFF;
    end
    upd_wr = p_req_r.valid && (p_req_r.kind == KIND_FREE || p_req_r.kind == KIND_OCC ||
                               p_req_r.kind == KIND_CENTER);
  end

  assign rd_en_o    = req_i.valid;
  assign rd_addr_o  = addr_i;
  assign wr_en_o    = clr_busy_r || upd_wr;
  assign wr_addr_o  = clr_busy_r ? clr_addr_r : p_addr_r;
  assign wr_data_o  = clr_busy_r ? '0 : sat_val;
  assign clr_busy_o = clr_busy_r;
  assign cap_o      = cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_req_r    <= '0;
      fwd_r      <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      p_req_r <= req_i;
      fwd_r   <= upd_wr && req_i.valid && (p_addr_r == addr_i);
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r   <= addr_i;
    fwd_data_r <= sat_val;
    if (p_req_r.valid) begin
      case (p_req_r.kind)
        KIND_CENTER: cap_r <= sat_val;
        KIND_READ:   cap_r <= operand;
        KIND_ZERO:   cap_r <= '0;
        default:     cap_r <= cap_r;
      endcase
    end
  end

endmodule

// ===== sv/ogru_ray_seq.sv =====
// Request sequencer: Bresenham walk, 3x3 end block, reads, and the result register.
// Uses ogru_pkg; issues at most one request a cycle to ogru_cell_update.
module ogru_ray_seq #(
  parameter int unsigned GRID_SIDE = 128,
  parameter int unsigned AW        = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [ogru_pkg::COORD_W-1:0]       in_start_x,
  input  logic [ogru_pkg::COORD_W-1:0]       in_start_y,
  input  logic [ogru_pkg::COORD_W-1:0]       in_end_x,
  input  logic [ogru_pkg::COORD_W-1:0]       in_end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ogru_pkg::cell_t                    out_cell_value,
  output logic                               out_cell_occupied,
  output logic [ogru_pkg::COUNT_W-1:0]       out_cells_touched,
  input  logic                               clr_busy_i,
  input  ogru_pkg::cell_t                    cap_i,
  output ogru_pkg::upd_req_t                 req_o,
  output logic [AW-1:0]                      addr_o
);
  import ogru_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_NEIGH = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [10:0] SIDE = 11'(GRID_SIDE);

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] cx, input logic [8:0] cy);
    logic [AW+9:0] t;
    t = (AW+10)'(cx) * (AW+10)'(GRID_SIDE) + (AW+10)'(cy);
    return t[AW-1:0];
  endfunction

  logic [2:0]            state_r;
  logic                  mode_r;
  logic [COORD_W-1:0]    st_x_r, st_y_r, end_x_r, end_y_r;
  logic [COORD_W-1:0]    walk_x_r, walk_y_r;
  logic signed [ERR_W-1:0] walk_error_r;
  logic [7:0]            ax_r, ay_r;
  logic [1:0]            sx_r, sy_r;
  logic                  major_x_r;
  logic [1:0]            ni_r, nj_r;
  logic [COUNT_W-1:0]    touched_r;
  logic                  out_valid_r;
  cell_t                 out_value_r;
  logic [COUNT_W-1:0]    out_touched_r;

  logic                  start_in, end_in, ray_ok;
  logic [7:0]            dx, dy, adx, ady, ax0, ay0;
  logic [1:0]            sx0, sy0;
  logic                  major0;
  logic signed [ERR_W-1:0] err0;
  logic                  walk_active, step_minor;
  logic [7:0]            amaj, amin;
  logic signed [ERR_W-1:0] walk_error_nxt;
  logic [COORD_W-1:0]    walk_x_nxt, walk_y_nxt;
  logic [8:0]            nx, ny;
  logic                  nb_in;
  logic                  accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !clr_busy_i;

  always_comb begin
    start_in = ({4'b0000, st_x_r} < SIDE) && ({4'b0000, st_y_r} < SIDE);
    end_in   = ({4'b0000, end_x_r} < SIDE) && ({4'b0000, end_y_r} < SIDE);
    ray_ok   = start_in && end_in;

    dx  = {1'b0, end_x_r} - {1'b0, st_x_r};
    dy  = {1'b0, end_y_r} - {1'b0, st_y_r};
    adx = dx[7] ? -dx : dx;
    ady = dy[7] ? -dy : dy;
    ax0 = {adx[6:0], 1'b0};
    ay0 = {ady[6:0], 1'b0};
    sx0 = (dx == 8'd0) ? 2'b00 : (dx[7] ? 2'b11 : 2'b01);
    sy0 = (dy == 8'd0) ? 2'b00 : (dy[7] ? 2'b11 : 2'b01);
    major0 = ax0 >= ay0;
    if (major0) begin
      err0 = $signed({2'b00, ay0}) - $signed({3'b000, adx[6:0]});
    end else begin
      err0 = $signed({2'b00, ax0}) - $signed({3'b000, ady[6:0]});
    end

    amaj = major_x_r ? ax_r : ay_r;
    amin = major_x_r ? ay_r : ax_r;
    walk_active = major_x_r ? (walk_x_r != end_x_r) : (walk_y_r != end_y_r);
    step_minor  = (walk_error_r > 0) ||
                  (walk_error_r == 0 && (major_x_r ? (sx_r == 2'b01) : (sy_r == 2'b01)));
    walk_error_nxt = walk_error_r - (step_minor ? $signed({2'b00, amaj}) : '0)
                     + $signed({2'b00, amin});
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    if (major_x_r || step_minor) begin
      walk_x_nxt = walk_x_r + {{5{sx_r[1]}}, sx_r};
    end
    if (!major_x_r || step_minor) begin
      walk_y_nxt = walk_y_r + {{5{sy_r[1]}}, sy_r};
    end

    nx = {2'b00, end_x_r} + {7'b0, ni_r} - 9'd1;
    ny = {2'b00, end_y_r} + {7'b0, nj_r} - 9'd1;
    nb_in = !nx[8] && !ny[8] && ({2'b00, nx} < SIDE) && ({2'b00, ny} < SIDE);

    req_o  = '0;
    addr_o = '0;
    unique case (state_r)
      S_SETUP: begin
        req_o.valid = !mode_r ? !ray_ok : 1'b1;
        req_o.kind  = (mode_r && start_in) ? KIND_READ : KIND_ZERO;
        addr_o      = cell_addr({2'b00, st_x_r}, {2'b00, st_y_r});
      end
      S_WALK: begin
        req_o.valid = walk_active;
        req_o.kind  = KIND_FREE;
        addr_o      = cell_addr({2'b00, walk_x_r}, {2'b00, walk_y_r});
      end
      S_NEIGH: begin
        req_o.valid = nb_in;
        req_o.kind  = (ni_r == 2'd1 && nj_r == 2'd1) ? KIND_CENTER : KIND_OCC;
        addr_o      = cell_addr(nx, ny);
      end
      default: begin
        req_o  = '0;
        addr_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      walk_x_r     <= '0;
      walk_y_r     <= '0;
      walk_error_r <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (!mode_r && ray_ok) begin
            walk_x_r     <= st_x_r;
            walk_y_r     <= st_y_r;
            walk_error_r <= err0;
            state_r      <= S_WALK;
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_WALK: begin
          if (walk_active) begin
            walk_x_r     <= walk_x_nxt;
            walk_y_r     <= walk_y_nxt;
            walk_error_r <= walk_error_nxt;
          end else begin
            state_r <= S_NEIGH;
          end
        end
        S_NEIGH: begin
          if (ni_r == 2'd2 && nj_r == 2'd2) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      st_x_r    <= in_start_x;
      st_y_r    <= in_start_y;
      end_x_r   <= in_end_x;
      end_y_r   <= in_end_y;
      touched_r <= '0;
    end
    if (state_r == S_SETUP) begin
      ax_r      <= ax0;
      ay_r      <= ay0;
      sx_r      <= sx0;
      sy_r      <= sy0;
      major_x_r <= major0;
    end
    if (state_r == S_WALK && !walk_active) begin
      ni_r <= 2'd0;
      nj_r <= 2'd0;
    end
    if (state_r == S_NEIGH) begin
      if (nj_r == 2'd2) begin
        nj_r <= 2'd0;
        ni_r <= ni_r + 2'd1;
      end else begin
        nj_r <= nj_r + 2'd1;
      end
    end
    if ((state_r == S_WALK || state_r == S_NEIGH) && req_o.valid) begin
      touched_r <= touched_r + 1'b1;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_value_r   <= cap_i;
      out_touched_r <= touched_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_value_r;
  assign out_cell_occupied = (out_value_r > 0);
  assign out_cells_touched = out_touched_r;

endmodule

// ===== verif/tb_occupancy_grid_ray_update.sv =====
// Self-checking testbench for occupancy_grid_ray_update: ray and read requests with random
// gaps and stalls, each result checked against a log-odds grid predictor kept here.
// Depends on ogru_pkg and occupancy_grid_ray_update.
module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  localparam int GRID_SIDE = 128;
  localparam int RESET_WEIGHT = 166;
  localparam int STALL_LIMIT = 50000;
  localparam int CELL_MAX = 32767;
  localparam int CELL_MIN = -32768;
  localparam logic MODE_TRACE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct {
    logic               mode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } grid_request_t;

  typedef struct {
    cell_t              value;
    logic               occupied;
    logic [COUNT_W-1:0] touched;
  } cell_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [COORD_W-1:0] in_start_x = '0;
  logic [COORD_W-1:0] in_start_y = '0;
  logic [COORD_W-1:0] in_end_x = '0;
  logic [COORD_W-1:0] in_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cell_t out_cell_value;
  logic out_cell_occupied;
  logic [COUNT_W-1:0] out_cells_touched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_OCCUPIED_WEIGHT;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  cell_t log_odds [GRID_SIDE*GRID_SIDE] = '{default: '0};
  logic [WEIGHT_W-1:0] occupied_weight = WEIGHT_W'(RESET_WEIGHT);
  logic [WEIGHT_W-1:0] free_weight = WEIGHT_W'(RESET_WEIGHT);

  grid_request_t requests_to_send[$];
  cell_report_t cell_reports_due[$];
  grid_request_t outgoing;
  cell_report_t due_report;
  logic [COORD_W-1:0] last_end_x = '0;
  logic [COORD_W-1:0] last_end_y = '0;
  logic request_taken = 1'b0;
  int requests_queued = 0;
  int requests_accepted = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_cycles = 0;
  int mismatches = 0;
  bit moved;

  occupancy_grid_ray_update #(
    .GRID_SIDE(GRID_SIDE)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_value   (out_cell_value),
    .out_cell_occupied(out_cell_occupied),
    .out_cells_touched(out_cells_touched),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic void bump_cell(int x, int y, int delta);
    int sum;
    sum = int'(log_odds[x*GRID_SIDE + y]) + delta;
    if (sum > CELL_MAX) sum = CELL_MAX;
    else if (sum < CELL_MIN) sum = CELL_MIN;
    log_odds[x*GRID_SIDE + y] = cell_t'(sum);
  endfunction

  function automatic cell_report_t apply_request(logic mode, int x, int y, int ex, int ey);
    cell_report_t r;
    int dx, dy, sx, sy, ax, ay, err, i, j, touched;
    touched = 0;
    if (mode == MODE_READ) begin
      r.value = log_odds[x*GRID_SIDE + y];
    end else begin
      dx = ex - x;
      dy = ey - y;
      sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      ax = ((dx < 0) ? -dx : dx) * 2;
      ay = ((dy < 0) ? -dy : dy) * 2;
      if (ax >= ay) begin
        err = ay - ax / 2;
        while (x != ex) begin
          bump_cell(x, y, -int'(free_weight));
          touched++;
          if (err > 0 || (err == 0 && sx > 0)) begin
            err -= ax;
            y += sy;
          end
          err += ay;
          x += sx;
        end
      end else begin
        err = ax - ay / 2;
        while (y != ey) begin
          bump_cell(x, y, -int'(free_weight));
          touched++;
          if (err > 0 || (err == 0 && sy > 0)) begin
            err -= ay;
            x += sx;
          end
          err += ax;
          y += sy;
        end
      end
      for (i = -1; i < 2; i++) begin
        for (j = -1; j < 2; j++) begin
          if (ex + i >= 0 && ex + i < GRID_SIDE && ey + j >= 0 && ey + j < GRID_SIDE) begin
            bump_cell(ex + i, ey + j, int'(occupied_weight));
            touched++;
          end
        end
      end
      r.value = log_odds[ex*GRID_SIDE + ey];
    end
    r.occupied = (r.value > 0);
    r.touched = COUNT_W'(touched);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > GRID_SIDE - 1) v = GRID_SIDE - 1;
    return COORD_W'(v);
  endfunction

  function automatic int window_base();
    case ($urandom_range(3))
      0: return 0;
      1: return GRID_SIDE - 16;
      default: return int'($urandom_range(GRID_SIDE - 16));
    endcase
  endfunction

  function automatic grid_request_t random_request();
    grid_request_t r;
    int pick, bx, by;
    pick = $urandom_range(99);
    r.mode = MODE_TRACE;
    r.start_x = COORD_W'($urandom_range(GRID_SIDE - 1));
    r.start_y = COORD_W'($urandom_range(GRID_SIDE - 1));
    r.end_x = COORD_W'($urandom_range(GRID_SIDE - 1));
    r.end_y = COORD_W'($urandom_range(GRID_SIDE - 1));
    if (pick < 30) begin
      r.mode = MODE_READ;
      if (pick < 20) begin
        r.start_x = near_coord(last_end_x);
        r.start_y = near_coord(last_end_y);
      end
    end else if (pick >= 55) begin
      // Short rays in a small window pile updates onto the same cells.
      bx = window_base();
      by = window_base();
      r.start_x = COORD_W'(bx + $urandom_range(15));
      r.start_y = COORD_W'(by + $urandom_range(15));
      r.end_x = COORD_W'(bx + $urandom_range(15));
      r.end_y = COORD_W'(by + $urandom_range(15));
      if (pick >= 92) begin
        r.end_x = r.start_x;
        r.end_y = r.start_y;
      end
    end
    if (r.mode == MODE_TRACE) begin
      last_end_x = r.end_x;
      last_end_y = r.end_y;
    end
    return r;
  endfunction

  task automatic queue_request(grid_request_t r);
    requests_to_send.push_back(r);
    requests_queued++;
  endtask

  task automatic queue_ray(int sx, int sy, int ex, int ey);
    grid_request_t r;
    r.mode = MODE_TRACE;
    r.start_x = COORD_W'(sx);
    r.start_y = COORD_W'(sy);
    r.end_x = COORD_W'(ex);
    r.end_y = COORD_W'(ey);
    queue_request(r);
  endtask

  task automatic queue_read(int x, int y);
    grid_request_t r;
    r.mode = MODE_READ;
    r.start_x = COORD_W'(x);
    r.start_y = COORD_W'(y);
    r.end_x = COORD_W'($urandom_range(GRID_SIDE - 1));
    r.end_y = COORD_W'($urandom_range(GRID_SIDE - 1));
    queue_request(r);
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_request(random_request());
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    while (requests_accepted != requests_queued || cell_reports_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_weight(logic index, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= WEIGHT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic enter_phase(int occ_w, int free_w, int send_pct, int stall_pct);
    wait_until_drained();
    write_weight(REG_OCCUPIED_WEIGHT, occ_w);
    write_weight(REG_FREE_WEIGHT, free_w);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && (!in_valid || request_taken)) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        outgoing = requests_to_send.pop_front();
        in_valid <= 1'b1;
        in_mode <= outgoing.mode;
        in_start_x <= outgoing.start_x;
        in_start_y <= outgoing.start_y;
        in_end_x <= outgoing.end_x;
        in_end_y <= outgoing.end_y;
      end else begin
        in_valid <= 1'b0;
      end
    end
    request_taken <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (cell_reports_due.size() == 0) begin
          report_mismatch($sformatf("result value %0d with no request outstanding",
                                    out_cell_value));
        end else begin
          due_report = cell_reports_due.pop_front();
          if (out_cell_value !== due_report.value)
            report_mismatch($sformatf("cell_value got %0d expected %0d",
                                      out_cell_value, due_report.value));
          if (out_cell_occupied !== due_report.occupied)
            report_mismatch($sformatf("cell_occupied got %0d expected %0d",
                                      out_cell_occupied, due_report.occupied));
          if (out_cells_touched !== due_report.touched)
            report_mismatch($sformatf("cells_touched got %0d expected %0d",
                                      out_cells_touched, due_report.touched));
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        request_taken <= 1'b1;
        requests_accepted++;
        cell_reports_due.push_back(apply_request(in_mode, in_start_x, in_start_y,
                                                 in_end_x, in_end_y));
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == REG_OCCUPIED_WEIGHT) occupied_weight <= cfg_data;
        else free_weight <= cfg_data;
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb_occupancy_grid_ray_update NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    queue_read(0, 0);
    queue_read(127, 127);
    queue_ray(0, 0, 0, 0);
    queue_ray(127, 127, 127, 127);
    queue_ray(0, 127, 127, 0);
    queue_ray(127, 0, 0, 127);
    queue_ray(0, 64, 127, 64);
    queue_ray(127, 65, 0, 65);
    queue_ray(64, 0, 64, 127);
    queue_ray(65, 127, 65, 0);
    queue_ray(10, 10, 14, 12);
    queue_ray(14, 12, 10, 10);
    queue_ray(20, 20, 22, 24);
    queue_ray(22, 24, 20, 20);
    queue_read(11, 11);
    queue_read(0, 64);
    queue_read(127, 64);
    queue_ray(0, 0, 127, 1);

    enter_phase(32767, 32767, 0, 0);
    queue_ray(40, 40, 40, 40);
    queue_ray(40, 40, 40, 40);
    queue_read(41, 41);
    queue_ray(30, 40, 50, 40);
    queue_ray(30, 40, 50, 40);
    queue_read(30, 40);
    queue_random(200);

    enter_phase(0, 0, 62, 0);
    queue_random(250);

    enter_phase($urandom_range(32767), $urandom_range(32767), 0, 62);
    queue_random(125);
    wait_until_drained();
    queue_random(125);

    enter_phase(1, 32767, 33, 33);
    queue_random(250);

    enter_phase(32767, 0, 62, 0);
    queue_random(250);

    enter_phase($urandom_range(32767), $urandom_range(32767), 0, 0);
    queue_random(250);

    wait_until_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_occupancy_grid_ray_update OK");
    end else begin
      $display("tb_occupancy_grid_ray_update NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ogru_pkg.sv
sv/ogru_grid_mem.sv
sv/ogru_cell_update.sv
sv/ogru_ray_seq.sv
sv/occupancy_grid_ray_update.sv
verif/tb_occupancy_grid_ray_update.sv
